// File: hw/rtl/byte_code_cpu_step_unit_defines.svh
// Assertion macros shared by the step unit RTL.
`ifndef BYTE_CODE_CPU_STEP_UNIT_DEFINES_SVH
`define BYTE_CODE_CPU_STEP_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BCCS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bccs: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define BCCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bccs: next-cycle check failed");

`endif

// File: hw/rtl/bccs_pkg.sv
// Shared constants, types and helper functions of the byte-code step unit.
package bccs_pkg;

   localparam int DATA_W    = 8;
   localparam int MEM_DEPTH = 256;
   localparam int NUM_REGS  = 16;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int REG_AW    = $clog2(NUM_REGS);
   localparam int LEN_W     = 3;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_STEP = 1'b1;

   localparam logic [DATA_W-1:0] FLAG_BYTE = 8'hff;

   localparam logic [DATA_W-1:0] OP_NOP   = 8'h00;
   localparam logic [DATA_W-1:0] OP_ADD   = 8'h01;
   localparam logic [DATA_W-1:0] OP_SUB   = 8'h02;
   localparam logic [DATA_W-1:0] OP_LD    = 8'h03;
   localparam logic [DATA_W-1:0] OP_JMP   = 8'h04;
   localparam logic [DATA_W-1:0] OP_CMP   = 8'h05;
   localparam logic [DATA_W-1:0] OP_JE    = 8'h06;
   localparam logic [DATA_W-1:0] OP_JNE   = 8'h07;
   localparam logic [DATA_W-1:0] OP_JGT   = 8'h08;
   localparam logic [DATA_W-1:0] OP_JLT   = 8'h09;
   localparam logic [DATA_W-1:0] OP_INC   = 8'h0a;
   localparam logic [DATA_W-1:0] OP_DEC   = 8'h0b;
   localparam logic [DATA_W-1:0] OP_PRINT = 8'h0c;
   localparam logic [DATA_W-1:0] OP_HALT  = 8'h0d;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BADREG  = 3'd1;
   localparam logic [2:0] ST_UNKNOWN = 3'd2;
   localparam logic [2:0] ST_HALT    = 3'd3;
   localparam logic [2:0] ST_REFUSED = 3'd4;

   localparam logic [1:0] CMP_EQ = 2'd0;
   localparam logic [1:0] CMP_GT = 2'd1;
   localparam logic [1:0] CMP_LT = 2'd2;

   localparam logic [1:0] ALU_ADD  = 2'd0;
   localparam logic [1:0] ALU_SUB  = 2'd1;
   localparam logic [1:0] ALU_PASS = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic [1:0]        cmp;
   } alu_rsp_type;

   typedef logic [255:0][MEM_AW-1:0] mem_map_type;
   typedef logic [255:0][REG_AW-1:0] reg_map_type;

   // Byte to address and byte to register index maps, built at elaboration.
   function automatic mem_map_type build_mem_map();
      mem_map_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = MEM_AW'(i % MEM_DEPTH);
      end
      return t;
   endfunction

   function automatic reg_map_type build_reg_map();
      reg_map_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = REG_AW'(i % NUM_REGS);
      end
      return t;
   endfunction

   localparam mem_map_type MEM_MAP = build_mem_map();
   localparam reg_map_type REG_MAP = build_reg_map();

   function automatic logic [MEM_AW-1:0] mem_wrap(input logic [DATA_W-1:0] b);
      return MEM_MAP[b];
   endfunction

   function automatic logic [REG_AW-1:0] reg_wrap(input logic [DATA_W-1:0] b);
      return REG_MAP[b];
   endfunction

   // The pc stays below the depth and the offset is small, so one subtract wraps it.
   function automatic logic [MEM_AW-1:0] pc_add(input logic [MEM_AW-1:0] pc,
                                                 input logic [LEN_W-1:0] off);
      logic [MEM_AW:0] s;
      s = {1'b0, pc} + (MEM_AW+1)'(off);
      if (s >= (MEM_AW+1)'(MEM_DEPTH)) begin
         s = s - (MEM_AW+1)'(MEM_DEPTH);
      end
      return s[MEM_AW-1:0];
   endfunction

endpackage

// File: hw/rtl/bccs_req_if.sv
// Request channel interface: program byte writes and step commands.
interface bccs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [bccs_pkg::DATA_W-1:0]   load_addr;
   logic [bccs_pkg::DATA_W-1:0]   load_byte;

   modport source (output valid, req_type, load_addr, load_byte, input ready);
   modport sink (input valid, req_type, load_addr, load_byte, output ready);
endinterface

// File: hw/rtl/bccs_rsp_if.sv
// Response channel interface: status and visible machine state per transaction.
interface bccs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [2:0]                    status;
   logic [bccs_pkg::DATA_W-1:0]   pc_after;
   logic                          halted;
   logic                          print_valid;
   logic [bccs_pkg::DATA_W-1:0]   print_value;
   logic [1:0]                    compare_state;

   modport source (output valid, status, pc_after, halted, print_valid, print_value,
                   compare_state, input ready);
   modport sink (input valid, status, pc_after, halted, print_valid, print_value,
                 compare_state, output ready);
endinterface

// File: hw/rtl/bccs_ram.sv
// Generic single-port RAM with registered read data.
module bccs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bccs_alu.sv
// Shared 8-bit add/subtract/pass unit that also yields the three-way compare result.
module bccs_alu (
   input  bccs_pkg::alu_req_type req,
   output bccs_pkg::alu_rsp_type rsp
);

   logic [bccs_pkg::DATA_W-1:0] b_eff;
   logic                        cin;
   logic [bccs_pkg::DATA_W:0]   sum;

   always_comb begin
      cin   = (req.op == bccs_pkg::ALU_SUB);
      b_eff = cin ? ~req.b : req.b;
      sum   = {1'b0, req.a} + {1'b0, b_eff} + (bccs_pkg::DATA_W+1)'(cin);

      case (req.op)
         bccs_pkg::ALU_ADD, bccs_pkg::ALU_SUB: begin
            rsp.result = sum[bccs_pkg::DATA_W-1:0];
         end
         default: begin
            rsp.result = req.b;
         end
      endcase

      // For a subtract, the carry out is set exactly when a is not below b.
      if (sum[bccs_pkg::DATA_W-1:0] == '0) begin
         rsp.cmp = bccs_pkg::CMP_EQ;
      end else if (sum[bccs_pkg::DATA_W]) begin
         rsp.cmp = bccs_pkg::CMP_GT;
      end else begin
         rsp.cmp = bccs_pkg::CMP_LT;
      end
   end

endmodule

// File: hw/rtl/byte_code_cpu_step_unit.sv
// Top level of the byte-code step unit: sequencer, register file, program memory.
//
//   channel  direction  transaction
//   req      in         req_type, load_addr, load_byte
//   rsp      out        status, pc_after, halted, print_valid, print_value, compare_state
//
// A load or a refused step goes from accept straight to the output register; another step
// passes accept, one fetch state per instruction byte read from the single-port program
// memory, an execute state on the shared ALU for register writes and compares, and the
// output register. After reset the program memory is swept to zero with req.ready low.
// A new transaction is taken once the previous result sits in the output register, and
// the sequencer waits in its last cycle while rsp stalls with a result.
`include "byte_code_cpu_step_unit_defines.svh"

module byte_code_cpu_step_unit (
   input logic         clock,
   input logic         reset,
   bccs_req_if.sink    req,
   bccs_rsp_if.source  rsp
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_F0    = 4'd2;
   localparam logic [3:0] S_F1    = 4'd3;
   localparam logic [3:0] S_F2    = 4'd4;
   localparam logic [3:0] S_F3    = 4'd5;
   localparam logic [3:0] S_F4    = 4'd6;
   localparam logic [3:0] S_EXEC  = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   logic [3:0]                    state_ff, state_in;
   logic [bccs_pkg::MEM_AW-1:0]   clr_ff, clr_in;
   logic [bccs_pkg::MEM_AW-1:0]   pc_ff, pc_in;
   logic [1:0]                    cmp_ff, cmp_in;
   logic                          halt_ff, halt_in;
   logic [bccs_pkg::DATA_W-1:0]   op_ff, op_in;
   logic [bccs_pkg::REG_AW-1:0]   rd_ff, rd_in;
   logic [bccs_pkg::DATA_W-1:0]   src_ff, src_in;
   logic [bccs_pkg::LEN_W-1:0]    len_ff, len_in;
   logic [1:0]                    alu_op_ff, alu_op_in;
   logic [2:0]                    status_ff, status_in;
   logic                          pv_ff, pv_in;
   logic [bccs_pkg::DATA_W-1:0]   pval_ff, pval_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_load;
   logic [2:0]                    rsp_status_ff;
   logic [bccs_pkg::DATA_W-1:0]   rsp_pc_ff;
   logic                          rsp_halted_ff;
   logic                          rsp_print_valid_ff;
   logic [bccs_pkg::DATA_W-1:0]   rsp_print_value_ff;
   logic [1:0]                    rsp_cmp_ff;

   logic                          ram_we;
   logic [bccs_pkg::MEM_AW-1:0]   ram_addr;
   logic [bccs_pkg::DATA_W-1:0]   ram_wdata;
   logic [bccs_pkg::DATA_W-1:0]   ram_rdata;

   logic [bccs_pkg::DATA_W-1:0]   regs_ff [bccs_pkg::NUM_REGS];
   logic [bccs_pkg::REG_AW-1:0]   reg_raddr;
   logic [bccs_pkg::DATA_W-1:0]   reg_rdata;
   logic                          reg_we;
   logic [bccs_pkg::DATA_W-1:0]   reg_wdata;

   bccs_pkg::alu_req_type         alu_req;
   bccs_pkg::alu_rsp_type         alu_rsp;
   logic                          req_acc;
   logic                          load_acc;
   logic                          rsp_print;
   logic                          taken;

   bccs_ram #(
      .WIDTH (bccs_pkg::DATA_W),
      .DEPTH (bccs_pkg::MEM_DEPTH)
   ) u_prog_mem (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   bccs_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign req_acc   = req.valid && req.ready;
   assign load_acc  = req_acc && (req.req_type == bccs_pkg::REQ_LOAD);
   assign rsp_print = rsp_valid_ff && rsp_print_valid_ff;

   // One register read port: the destination during execute, else the byte just fetched.
   assign reg_raddr = (state_ff == S_EXEC) ? rd_ff : bccs_pkg::reg_wrap(ram_rdata);
   assign reg_rdata = regs_ff[reg_raddr];

   assign alu_req.op = alu_op_ff;
   assign alu_req.a  = reg_rdata;
   assign alu_req.b  = src_ff;

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pc_in     = pc_ff;
      cmp_in    = cmp_ff;
      halt_in   = halt_ff;
      op_in     = op_ff;
      rd_in     = rd_ff;
      src_in    = src_ff;
      len_in    = len_ff;
      alu_op_in = alu_op_ff;
      status_in = status_ff;
      pv_in     = pv_ff;
      pval_in   = pval_ff;
      ram_we    = 1'b0;
      ram_addr  = pc_ff;
      ram_wdata = '0;
      reg_we    = 1'b0;
      reg_wdata = alu_rsp.result;
      rsp_load  = 1'b0;
      taken     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;

      case (state_ff)
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + bccs_pkg::MEM_AW'(1);
            if (clr_ff == bccs_pkg::MEM_AW'(bccs_pkg::MEM_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               status_in = bccs_pkg::ST_OK;
               pv_in     = 1'b0;
               pval_in   = '0;
               if (req.req_type == bccs_pkg::REQ_LOAD) begin
                  ram_we    = 1'b1;
                  ram_addr  = bccs_pkg::mem_wrap(req.load_addr);
                  ram_wdata = req.load_byte;
                  state_in  = S_RESP;
               end else if (halt_ff) begin
                  status_in = bccs_pkg::ST_REFUSED;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_F0;
               end
            end
         end
         S_F0: begin
            op_in = ram_rdata;
            case (ram_rdata)
               bccs_pkg::OP_NOP: begin
                  pc_in    = bccs_pkg::pc_add(pc_ff, 3'd1);
                  state_in = S_RESP;
               end
               bccs_pkg::OP_HALT: begin
                  halt_in   = 1'b1;
                  status_in = bccs_pkg::ST_HALT;
                  state_in  = S_RESP;
               end
               bccs_pkg::OP_ADD, bccs_pkg::OP_SUB, bccs_pkg::OP_LD, bccs_pkg::OP_JMP,
               bccs_pkg::OP_CMP, bccs_pkg::OP_JE, bccs_pkg::OP_JNE, bccs_pkg::OP_JGT,
               bccs_pkg::OP_JLT, bccs_pkg::OP_INC, bccs_pkg::OP_DEC,
               bccs_pkg::OP_PRINT: begin
                  ram_addr = bccs_pkg::pc_add(pc_ff, 3'd1);
                  state_in = S_F1;
               end
               default: begin
                  pc_in     = bccs_pkg::pc_add(pc_ff, 3'd1);
                  status_in = bccs_pkg::ST_UNKNOWN;
                  state_in  = S_RESP;
               end
            endcase
         end
         S_F1: begin
            case (op_ff)
               bccs_pkg::OP_JMP: begin
                  pc_in    = bccs_pkg::mem_wrap(ram_rdata);
                  state_in = S_RESP;
               end
               bccs_pkg::OP_JE, bccs_pkg::OP_JNE, bccs_pkg::OP_JGT, bccs_pkg::OP_JLT: begin
                  case (op_ff)
                     bccs_pkg::OP_JE:  taken = (cmp_ff == bccs_pkg::CMP_EQ);
                     bccs_pkg::OP_JNE: taken = (cmp_ff != bccs_pkg::CMP_EQ);
                     bccs_pkg::OP_JGT: taken = (cmp_ff == bccs_pkg::CMP_GT);
                     default:          taken = (cmp_ff == bccs_pkg::CMP_LT);
                  endcase
                  pc_in    = taken ? bccs_pkg::mem_wrap(ram_rdata)
                                   : bccs_pkg::pc_add(pc_ff, 3'd2);
                  state_in = S_RESP;
               end
               bccs_pkg::OP_PRINT: begin
                  if (ram_rdata != bccs_pkg::FLAG_BYTE) begin
                     pv_in    = 1'b1;
                     pval_in  = ram_rdata;
                     pc_in    = bccs_pkg::pc_add(pc_ff, 3'd2);
                     state_in = S_RESP;
                  end else begin
                     ram_addr = bccs_pkg::pc_add(pc_ff, 3'd2);
                     state_in = S_F2;
                  end
               end
               default: begin
                  // Register forms: the byte after the opcode must be the flag byte.
                  if (ram_rdata != bccs_pkg::FLAG_BYTE) begin
                     status_in = bccs_pkg::ST_BADREG;
                     state_in  = S_RESP;
                  end else begin
                     ram_addr = bccs_pkg::pc_add(pc_ff, 3'd2);
                     state_in = S_F2;
                  end
               end
            endcase
         end
         S_F2: begin
            rd_in = bccs_pkg::reg_wrap(ram_rdata);
            case (op_ff)
               bccs_pkg::OP_PRINT: begin
                  pv_in    = 1'b1;
                  pval_in  = reg_rdata;
                  pc_in    = bccs_pkg::pc_add(pc_ff, 3'd3);
                  state_in = S_RESP;
               end
               bccs_pkg::OP_INC, bccs_pkg::OP_DEC: begin
                  src_in    = bccs_pkg::DATA_W'(1);
                  alu_op_in = (op_ff == bccs_pkg::OP_INC) ? bccs_pkg::ALU_ADD
                                                           : bccs_pkg::ALU_SUB;
                  len_in    = 3'd3;
                  state_in  = S_EXEC;
               end
               default: begin
                  ram_addr = bccs_pkg::pc_add(pc_ff, 3'd3);
                  state_in = S_F3;
               end
            endcase
         end
         S_F3: begin
            case (op_ff)
               bccs_pkg::OP_ADD: alu_op_in = bccs_pkg::ALU_ADD;
               bccs_pkg::OP_SUB: alu_op_in = bccs_pkg::ALU_SUB;
               bccs_pkg::OP_CMP: alu_op_in = bccs_pkg::ALU_SUB;
               default:          alu_op_in = bccs_pkg::ALU_PASS;
            endcase
            if (ram_rdata != bccs_pkg::FLAG_BYTE) begin
               src_in   = ram_rdata;
               len_in   = 3'd4;
               state_in = S_EXEC;
            end else begin
               ram_addr = bccs_pkg::pc_add(pc_ff, 3'd4);
               state_in = S_F4;
            end
         end
         S_F4: begin
            src_in   = reg_rdata;
            len_in   = 3'd5;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == bccs_pkg::OP_CMP) begin
               cmp_in = alu_rsp.cmp;
            end else begin
               reg_we = 1'b1;
            end
            pc_in    = bccs_pkg::pc_add(pc_ff, len_ff);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         cmp_ff       <= bccs_pkg::CMP_EQ;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < bccs_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         cmp_ff       <= cmp_in;
         halt_ff      <= halt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_we) begin
            regs_ff[rd_ff] <= reg_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      rd_ff     <= rd_in;
      src_ff    <= src_in;
      len_ff    <= len_in;
      alu_op_ff <= alu_op_in;
      status_ff <= status_in;
      pv_ff     <= pv_in;
      pval_ff   <= pval_in;
      if (rsp_load) begin
         rsp_status_ff      <= status_ff;
         rsp_pc_ff          <= bccs_pkg::DATA_W'(pc_ff);
         rsp_halted_ff      <= halt_ff;
         rsp_print_valid_ff <= pv_ff;
         rsp_print_value_ff <= pval_ff;
         rsp_cmp_ff         <= cmp_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.pc_after      = rsp_pc_ff;
   assign rsp.halted        = rsp_halted_ff;
   assign rsp.print_valid   = rsp_print_valid_ff;
   assign rsp.print_value   = rsp_print_value_ff;
   assign rsp.compare_state = rsp_cmp_ff;

   `BCCS_ASSERT_NEXT(a_load_goes_to_resp, clock, reset, load_acc, state_ff == S_RESP)
   `BCCS_ASSERT_NEXT(a_halt_sticky, clock, reset, halt_ff, halt_ff)
   `BCCS_ASSERT_NEXT(a_halt_freezes_pc, clock, reset, halt_ff, $stable(pc_ff))
   `BCCS_ASSERT_SAME(a_print_status_ok, clock, reset, rsp_print, rsp_status_ff == bccs_pkg::ST_OK)

endmodule
